// ===== hw/rtl/particle_emitter_scheduler_macros.svh =====
// Assertion helpers shared by the scheduler RTL.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef PARTICLE_EMITTER_SCHEDULER_MACROS_SVH
`define PARTICLE_EMITTER_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define PES_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PES_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pes_pkg.sv =====
`default_nettype none

package pes_pkg;

    // Command codes
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_PLAY = 2'd1;
    localparam logic [1:0] FUNC_STOP = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_START_DELAY = 3'd0;
    localparam logic [2:0] CFG_DURATION    = 3'd1;
    localparam logic [2:0] CFG_LOOPING     = 3'd2;
    localparam logic [2:0] CFG_BURST_COUNT = 3'd3;
    localparam logic [2:0] CFG_SPAWN_RATE  = 3'd4;
    localparam logic [2:0] CFG_MAX_COUNT   = 3'd5;
    localparam logic [2:0] CFG_DIST_LIMIT  = 3'd6;

    // Shortest period, 0.01 s in Q16.16
    localparam logic [31:0] MIN_DURATION = 32'd655;

    // Remainder unit retires one bit of the active time per cycle
    localparam int MOD_STEPS = 32;

    // Shared multiplier operand selects: three distance axes, then rate x delta
    localparam logic [1:0] MUL_SEL_DX   = 2'd0;
    localparam logic [1:0] MUL_SEL_DY   = 2'd1;
    localparam logic [1:0] MUL_SEL_DZ   = 2'd2;
    localparam logic [1:0] MUL_SEL_RATE = 2'd3;
    localparam int         MUL_ISSUES   = 4;

    typedef struct packed {
        logic       load;
        logic       play;
        logic       stop;
        logic       tick_start;
        logic       mod_init;
        logic       mod_step;
        logic       mod_fin;
        logic       mul_go;
        logic [1:0] mul_sel;
        logic       acc_go;
        logic [1:0] acc_sel;
        logic       acc_clear;
        logic       burst_go;
        logic       rate_go;
        logic       publish;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       playing;
        logic       dt_zero;
        logic       before_delay;
        logic       over_period;
        logic       looping;
        logic       in_range;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hw/rtl/particle_emitter_scheduler.sv =====
`default_nettype none

// Spawn scheduler for one particle emitter. Each input beat carries a tick, play or
// stop command and returns exactly one result beat with the clamped burst and rate
// spawn counts and the playing flag. One command is worked on at a time; a new beat
// is taken as soon as the previous one has reached the output register, even while
// that result is still stalled. Play, stop, unused codes and ticks while stopped or
// with zero delta go from decode to the output register; a tick still inside
// the start delay, or one that ends a one-shot period, passes the check state; a
// tick that reaches the distance test also runs the shared 32x32 multiplier, which
// issues the three squared distance terms and the rate increment one after
// another, then the burst and rate steps unless the emitter is out of range; a
// tick that wraps a looping period first runs the remainder unit, which resolves
// one bit of the active time per cycle. A result still stalled in the output
// register keeps the next one from being published until that one
// is taken. Configuration writes are always ready and take effect at once;
// write them only while no command is in flight.
module particle_emitter_scheduler
    import pes_pkg::*;
#(
    parameter int MAX_PARTICLES = 16384
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_func,
    input  wire logic [31:0]        i_delta_time,
    input  wire logic signed [31:0] i_emitter_x,
    input  wire logic signed [31:0] i_emitter_y,
    input  wire logic signed [31:0] i_emitter_z,
    input  wire logic signed [31:0] i_camera_x,
    input  wire logic signed [31:0] i_camera_y,
    input  wire logic signed [31:0] i_camera_z,
    input  wire logic [14:0]        i_owner_alive,
    input  wire logic [14:0]        i_live_total,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [14:0]             o_burst_spawned,
    output logic [14:0]             o_rate_spawned,
    output logic                    o_playing
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    pes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    pes_dp #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (i_func),
        .i_delta_time    (i_delta_time),
        .i_emitter_x     (i_emitter_x),
        .i_emitter_y     (i_emitter_y),
        .i_emitter_z     (i_emitter_z),
        .i_camera_x      (i_camera_x),
        .i_camera_y      (i_camera_y),
        .i_camera_z      (i_camera_z),
        .i_owner_alive   (i_owner_alive),
        .i_live_total    (i_live_total),
        .o_burst_spawned (o_burst_spawned),
        .o_rate_spawned  (o_rate_spawned),
        .o_playing       (o_playing)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/pes_dp.sv =====
`default_nettype none
`include "particle_emitter_scheduler_macros.svh"

module pes_dp
    import pes_pkg::*;
#(
    parameter int MAX_PARTICLES = 16384
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic [1:0]         i_func,
    input  wire logic [31:0]        i_delta_time,
    input  wire logic signed [31:0] i_emitter_x,
    input  wire logic signed [31:0] i_emitter_y,
    input  wire logic signed [31:0] i_emitter_z,
    input  wire logic signed [31:0] i_camera_x,
    input  wire logic signed [31:0] i_camera_y,
    input  wire logic signed [31:0] i_camera_z,
    input  wire logic [14:0]        i_owner_alive,
    input  wire logic [14:0]        i_live_total,
    output logic [14:0]             o_burst_spawned,
    output logic [14:0]             o_rate_spawned,
    output logic                    o_playing
);

    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int LW = (CW > 16) ? CW : 16;
    localparam logic [LW-1:0] MAX_P = LW'(MAX_PARTICLES);

    // Configuration
    logic [31:0] r_start_delay;
    logic [31:0] r_duration;
    logic        r_looping;
    logic [14:0] r_burst_count;
    logic [31:0] r_spawn_rate;
    logic [14:0] r_max_count;
    logic [31:0] r_dist_lim;

    // Held item
    logic [1:0]  r_func;
    logic [31:0] r_dt;
    logic [31:0] r_ex, r_ey, r_ez, r_cx, r_cy, r_cz;
    logic [14:0] r_owner;
    logic [14:0] r_total;

    // Emitter state
    logic        r_playing;
    logic [31:0] r_elapsed;
    logic        r_burst_done;
    logic [15:0] r_acc;

    // Working registers
    logic [31:0] r_ad [3];
    logic [31:0] r_act;
    logic [32:0] r_rem;
    logic [63:0] r_prod;
    logic [63:0] r_dist;
    logic [47:0] r_inc;
    logic [14:0] r_burst;
    logic [14:0] r_rate;
    logic [14:0] r_o_burst;
    logic [14:0] r_o_rate;
    logic        r_o_playing;

    logic [31:0] dur;
    logic [14:0] maxc;
    logic [32:0] elapsed_sum;
    logic [31:0] elapsed_sat;
    logic [31:0] active;
    logic [32:0] mod_t;
    logic [32:0] mod_next;
    logic [31:0] opa, opb;
    logic [63:0] mul_p;
    logic [64:0] dist_sum;
    logic [63:0] dist_sat;
    logic        in_range;
    logic [48:0] rate_sum;
    logic [32:0] whole;
    logic [14:0] burst_clamp;
    logic [14:0] rate_clamp;
    logic        burst_fire;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] nd;
        d  = $signed({a[31], a}) - $signed({b[31], b});
        nd = -d;
        return d[32] ? nd[31:0] : d[31:0];
    endfunction

    function automatic logic [14:0] clamp(input logic [32:0] want, input logic [16:0] owner,
                                          input logic [16:0] total,
                                          input logic [14:0] mc);
        logic [LW-1:0] tot;
        logic [LW-1:0] glob;
        logic [LW-1:0] own;
        logic [LW-1:0] lim;
        tot  = LW'(total);
        glob = (tot >= MAX_P) ? '0 : MAX_P - tot;
        own  = (owner >= {2'b0, mc}) ? '0 : LW'({2'b0, mc} - owner);
        lim  = (own < glob) ? own : glob;
        return (want < 33'(lim)) ? want[14:0] : lim[14:0];
    endfunction

    assign dur  = (r_duration < MIN_DURATION) ? MIN_DURATION : r_duration;
    assign maxc = (r_max_count == '0) ? 15'd1 : r_max_count;

    assign elapsed_sum = {1'b0, r_elapsed} + {1'b0, r_dt};
    assign elapsed_sat = elapsed_sum[32] ? '1 : elapsed_sum[31:0];
    assign active      = r_elapsed - r_start_delay;

    // One restoring step of active % dur
    assign mod_t    = {r_rem[31:0], r_act[31]};
    assign mod_next = (mod_t >= {1'b0, dur}) ? mod_t - {1'b0, dur} : mod_t;

    always_comb begin
        opa = r_spawn_rate;
        opb = r_dt;
        case (i_cmd.mul_sel)
            MUL_SEL_DX: begin
                opa = r_ad[0];
                opb = r_ad[0];
            end
            MUL_SEL_DY: begin
                opa = r_ad[1];
                opb = r_ad[1];
            end
            MUL_SEL_DZ: begin
                opa = r_ad[2];
                opb = r_ad[2];
            end
            default: begin
                opa = r_spawn_rate;
                opb = r_dt;
            end
        endcase
    end

    assign mul_p = opa * opb;

    assign dist_sum = {1'b0, r_dist} + {1'b0, r_prod};
    assign dist_sat = dist_sum[64] ? '1 : dist_sum[63:0];
    assign in_range = r_dist <= {r_dist_lim, 32'd0};

    assign rate_sum    = {33'd0, r_acc} + {1'b0, r_inc};
    assign whole       = rate_sum[48:16];
    assign burst_fire  = !r_burst_done && (r_burst_count != '0);
    assign burst_clamp = clamp({18'd0, r_burst_count}, {2'b0, r_owner}, {2'b0, r_total}, maxc);
    assign rate_clamp  = (whole != '0)
                       ? clamp(whole, {2'b0, r_owner} + {2'b0, r_burst},
                               {2'b0, r_total} + {2'b0, r_burst}, maxc)
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delay <= '0;
            r_duration    <= 32'd65536;
            r_looping     <= 1'b0;
            r_burst_count <= '0;
            r_spawn_rate  <= '0;
            r_max_count   <= 15'd1;
            r_dist_lim    <= 32'd640000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_DELAY: r_start_delay <= i_cfg_data;
                CFG_DURATION:    r_duration    <= i_cfg_data;
                CFG_LOOPING:     r_looping     <= i_cfg_data[0];
                CFG_BURST_COUNT: r_burst_count <= i_cfg_data[14:0];
                CFG_SPAWN_RATE:  r_spawn_rate  <= i_cfg_data;
                CFG_MAX_COUNT:   r_max_count   <= i_cfg_data[14:0];
                CFG_DIST_LIMIT:  r_dist_lim    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing    <= 1'b0;
            r_elapsed    <= '0;
            r_burst_done <= 1'b0;
            r_acc        <= '0;
        end else begin
            if (i_cmd.play) begin
                r_playing    <= 1'b1;
                r_elapsed    <= '0;
                r_burst_done <= 1'b0;
                r_acc        <= '0;
            end
            if (i_cmd.stop) begin
                r_playing <= 1'b0;
            end
            if (i_cmd.tick_start) begin
                r_elapsed <= elapsed_sat;
            end
            // wrap into the new period and re-arm the burst
            if (i_cmd.mod_fin) begin
                r_elapsed    <= r_start_delay + r_rem[31:0];
                r_burst_done <= 1'b0;
            end
            if (i_cmd.acc_clear) begin
                r_acc <= '0;
            end
            // a clamped burst still counts as done
            if (i_cmd.burst_go && burst_fire) begin
                r_burst_done <= 1'b1;
            end
            // drop the whole part, keep the fraction
            if (i_cmd.rate_go) begin
                r_acc <= rate_sum[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_dt    <= i_delta_time;
            r_ex    <= i_emitter_x;
            r_ey    <= i_emitter_y;
            r_ez    <= i_emitter_z;
            r_cx    <= i_camera_x;
            r_cy    <= i_camera_y;
            r_cz    <= i_camera_z;
            r_owner <= i_owner_alive;
            r_total <= i_live_total;
            r_burst <= '0;
            r_rate  <= '0;
        end
        if (i_cmd.tick_start) begin
            r_ad[0] <= abs_diff(r_ex, r_cx);
            r_ad[1] <= abs_diff(r_ey, r_cy);
            r_ad[2] <= abs_diff(r_ez, r_cz);
            r_dist  <= '0;
        end
        if (i_cmd.mod_init) begin
            r_act <= active;
            r_rem <= '0;
        end
        if (i_cmd.mod_step) begin
            r_rem <= mod_next;
            r_act <= {r_act[30:0], 1'b0};
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_p;
        end
        if (i_cmd.acc_go) begin
            if (i_cmd.acc_sel == MUL_SEL_RATE) begin
                r_inc <= r_prod[63:16];
            end else begin
                r_dist <= dist_sat;
            end
        end
        if (i_cmd.burst_go && burst_fire) begin
            r_burst <= burst_clamp;
        end
        if (i_cmd.rate_go) begin
            r_rate <= rate_clamp;
        end
        if (i_cmd.publish) begin
            r_o_burst   <= r_burst;
            r_o_rate    <= r_rate;
            r_o_playing <= r_playing;
        end
    end

    assign o_status.func         = r_func;
    assign o_status.playing      = r_playing;
    assign o_status.dt_zero      = (r_dt == '0);
    assign o_status.before_delay = (r_elapsed < r_start_delay);
    assign o_status.over_period  = (active > dur);
    assign o_status.looping      = r_looping;
    assign o_status.in_range     = in_range;

    assign o_burst_spawned = r_o_burst;
    assign o_rate_spawned  = r_o_rate;
    assign o_playing       = r_o_playing;

    `PES_ASSERT_IMP(a_rem_below_period, i_cmd.mod_step, !r_rem[32] && (r_rem[31:0] < dur), "remainder left the period range")
    `PES_ASSERT_NEXT(a_burst_once, i_cmd.burst_go && r_burst_done, r_burst == '0, "burst emitted twice in one period")
    `PES_ASSERT_NEXT(a_wrap_in_period, i_cmd.mod_fin, (r_elapsed - r_start_delay) < dur, "wrapped time left the period")

endmodule

`default_nettype wire

// ===== hw/rtl/pes_ctrl.sv =====
`default_nettype none
`include "particle_emitter_scheduler_macros.svh"

module pes_ctrl
    import pes_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_MOD,
        S_MODFIN,
        S_MUL,
        S_EMIT,
        S_RATE,
        S_FINISH
    } t_state;

    t_state      r_state, n_state;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_out_valid, n_out_valid;
    logic [4:0]  cnt_prev;

    assign cnt_prev = r_cnt - 5'd1;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                case (i_status.func)
                    FUNC_PLAY: o_cmd.play = 1'b1;
                    FUNC_STOP: o_cmd.stop = 1'b1;
                    FUNC_TICK: begin
                        if (i_status.playing && !i_status.dt_zero) begin
                            o_cmd.tick_start = 1'b1;
                            n_state          = S_CHECK;
                        end
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                n_cnt = '0;
                if (i_status.before_delay) begin
                    n_state = S_FINISH;
                end else if (i_status.over_period) begin
                    if (i_status.looping) begin
                        o_cmd.mod_init = 1'b1;
                        n_state        = S_MOD;
                    end else begin
                        o_cmd.stop = 1'b1;
                        n_state    = S_FINISH;
                    end
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + 5'd1;
                if (r_cnt == 5'(MOD_STEPS - 1)) begin
                    n_state = S_MODFIN;
                end
            end
            S_MODFIN: begin
                o_cmd.mod_fin = 1'b1;
                n_cnt         = '0;
                n_state       = S_MUL;
            end
            S_MUL: begin
                // issue a product, fold in the one from the cycle before
                n_cnt = r_cnt + 5'd1;
                if (r_cnt < 5'(MUL_ISSUES)) begin
                    o_cmd.mul_go  = 1'b1;
                    o_cmd.mul_sel = r_cnt[1:0];
                end
                if (r_cnt != '0) begin
                    o_cmd.acc_go  = 1'b1;
                    o_cmd.acc_sel = cnt_prev[1:0];
                end
                if (r_cnt == 5'(MUL_ISSUES)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_status.in_range) begin
                    o_cmd.acc_clear = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.burst_go = 1'b1;
                    n_state        = S_RATE;
                end
            end
            S_RATE: begin
                o_cmd.rate_go = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PES_ASSERT_NEXT(a_accept_decodes, i_in_valid && !o_in_stall, r_state == S_DECODE, "accepted beat not decoded")
    `PES_ASSERT_NEXT(a_result_kept, r_out_valid && i_out_stall, r_out_valid, "stalled result dropped")
    `PES_ASSERT_IMP(a_mod_length, r_state == S_MODFIN, $past(r_state, 33) == S_CHECK, "remainder pass has wrong length")

endmodule

`default_nettype wire

// ===== bench/particle_emitter_scheduler_checker.sv =====
// Watches the config, command and result channels of the spawn scheduler,
// keeps its own copy of the emitter state and checks every result beat.
module particle_emitter_scheduler_checker
    import pes_pkg::*;
#(
    parameter int MAX_PARTICLES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_delta_time,
    input  logic [31:0] i_emitter_x,
    input  logic [31:0] i_emitter_y,
    input  logic [31:0] i_emitter_z,
    input  logic [31:0] i_camera_x,
    input  logic [31:0] i_camera_y,
    input  logic [31:0] i_camera_z,
    input  logic [14:0] i_owner_alive,
    input  logic [14:0] i_live_total,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [14:0] i_burst_spawned,
    input  logic [14:0] i_rate_spawned,
    input  logic        i_playing,
    output int          o_pending,
    output int          o_fail_count
);

    typedef struct packed {
        logic [14:0] burst;
        logic [14:0] rate;
        logic        playing;
    } t_spawn_counts;

    t_spawn_counts spawn_expect_q[$];
    int            mismatches = 0;

    // Register copies
    logic [31:0] start_delay;
    logic [31:0] period;
    logic        looping;
    logic [14:0] burst_count;
    logic [31:0] spawn_rate;
    logic [14:0] max_count;
    logic [31:0] dist_limit_sq;

    // Emitter state
    logic        emitting;
    logic [31:0] elapsed_t;
    logic        burst_fired;
    logic [31:0] frac_acc;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
    end

    function automatic logic [63:0] axis_sq(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [63:0] m;
        d = {a[31], a} - {b[31], b};
        m = {31'd0, (d[32] ? (~d + 33'd1) : d)};
        return m * m;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic logic [63:0] clamp_to_headroom(input logic [63:0] want,
                                                      input logic [63:0] owner,
                                                      input logic [63:0] total);
        logic [63:0] cap, glob, own, lim;
        cap  = (max_count == '0) ? 64'd1 : 64'(max_count);
        glob = (total >= 64'(MAX_PARTICLES)) ? 64'd0 : 64'(MAX_PARTICLES) - total;
        own  = (owner >= cap) ? 64'd0 : cap - owner;
        lim  = (own < glob) ? own : glob;
        return (want < lim) ? want : lim;
    endfunction

    function automatic t_spawn_counts advance_emitter(input logic [1:0] f,
                                                      input logic [31:0] dt,
                                                      input logic [14:0] owner,
                                                      input logic [14:0] total);
        t_spawn_counts r;
        logic [32:0]   esum;
        logic [31:0]   dur, active;
        logic          go;
        logic [63:0]   burst, rate, dist_sq, sum, whole;
        burst = '0;
        rate  = '0;
        if (f == FUNC_PLAY) begin
            elapsed_t   = '0;
            burst_fired = 1'b0;
            frac_acc    = '0;
            emitting    = 1'b1;
        end else if (f == FUNC_STOP) begin
            emitting = 1'b0;
        end else if (f == FUNC_TICK && emitting && dt != '0) begin
            esum      = {1'b0, elapsed_t} + {1'b0, dt};
            elapsed_t = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
            if (elapsed_t >= start_delay) begin
                dur    = (period < MIN_DURATION) ? MIN_DURATION : period;
                active = elapsed_t - start_delay;
                go     = 1'b1;
                if (active > dur) begin
                    if (!looping) begin
                        emitting = 1'b0;
                        go       = 1'b0;
                    end else begin
                        elapsed_t   = start_delay + active % dur;
                        burst_fired = 1'b0;
                    end
                end
                if (go) begin
                    dist_sq = sat_sum(sat_sum(axis_sq(i_emitter_x, i_camera_x),
                                              axis_sq(i_emitter_y, i_camera_y)),
                                      axis_sq(i_emitter_z, i_camera_z));
                    if (dist_sq > {dist_limit_sq, 32'd0}) begin
                        frac_acc = '0;
                    end else begin
                        if (!burst_fired && burst_count != '0) begin
                            burst = clamp_to_headroom(64'(burst_count), 64'(owner),
                                                      64'(total));
                            burst_fired = 1'b1;
                        end
                        sum      = 64'(frac_acc) + ((64'(spawn_rate) * 64'(dt)) >> 16);
                        whole    = sum >> 16;
                        frac_acc = {16'd0, sum[15:0]};
                        // the whole part leaves the accumulator even when clamped
                        if (whole != '0)
                            rate = clamp_to_headroom(whole, 64'(owner) + burst,
                                                     64'(total) + burst);
                    end
                end
            end
        end
        r.burst   = burst[14:0];
        r.rate    = rate[14:0];
        r.playing = emitting;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_spawn_counts got, want, next_beat;
        if (!i_rst_n) begin
            start_delay   <= '0;
            period        <= 32'd65536;
            looping       <= 1'b0;
            burst_count   <= '0;
            spawn_rate    <= '0;
            max_count     <= 15'd1;
            dist_limit_sq <= 32'd640000;
            emitting      = 1'b0;
            elapsed_t     = '0;
            burst_fired   = 1'b0;
            frac_acc      = '0;
            spawn_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_START_DELAY: start_delay   <= i_cfg_data;
                    CFG_DURATION:    period        <= i_cfg_data;
                    CFG_LOOPING:     looping       <= i_cfg_data[0];
                    CFG_BURST_COUNT: burst_count   <= i_cfg_data[14:0];
                    CFG_SPAWN_RATE:  spawn_rate    <= i_cfg_data;
                    CFG_MAX_COUNT:   max_count     <= i_cfg_data[14:0];
                    CFG_DIST_LIMIT:  dist_limit_sq <= i_cfg_data;
                    default: ;
                endcase
            end
            // retire the oldest expectation before taking a new command beat
            if (i_out_valid && !i_out_stall) begin
                got.burst   = i_burst_spawned;
                got.rate    = i_rate_spawned;
                got.playing = i_playing;
                if (spawn_expect_q.size() == 0) begin
                    $error("result beat with no command waiting: burst %0d rate %0d playing %0d",
                           got.burst, got.rate, got.playing);
                    mismatches++;
                end else begin
                    want = spawn_expect_q.pop_front();
                    if (got.burst !== want.burst) begin
                        $error("burst_spawned: expected %0d, got %0d", want.burst, got.burst);
                        mismatches++;
                    end
                    if (got.rate !== want.rate) begin
                        $error("rate_spawned: expected %0d, got %0d", want.rate, got.rate);
                        mismatches++;
                    end
                    if (got.playing !== want.playing) begin
                        $error("playing: expected %0d, got %0d", want.playing, got.playing);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                next_beat = advance_emitter(i_func, i_delta_time, i_owner_alive,
                                            i_live_total);
                spawn_expect_q = {spawn_expect_q, next_beat};
            end
        end
        o_pending    <= spawn_expect_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== bench/particle_emitter_scheduler_tb.sv =====
module particle_emitter_scheduler_tb;
    import pes_pkg::*;

    localparam int         MAX_PARTICLES = 16384;
    localparam int         RAND_PHASES   = 8;
    localparam int         PHASE_ITEMS   = 119;
    localparam logic [1:0] FUNC_UNUSED   = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] dt;
        logic [31:0] ex, ey, ez, cx, cy, cz;
        logic [14:0] owner, total;
    } emit_cmd_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = '0;
    logic [31:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [1:0]  func       = '0;
    logic [31:0] delta_time = '0;
    logic [31:0] emitter_x  = '0;
    logic [31:0] emitter_y  = '0;
    logic [31:0] emitter_z  = '0;
    logic [31:0] camera_x   = '0;
    logic [31:0] camera_y   = '0;
    logic [31:0] camera_z   = '0;
    logic [14:0] owner_alive = '0;
    logic [14:0] live_total  = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [14:0] burst_spawned;
    logic [14:0] rate_spawned;
    logic        playing;

    int          pending;
    int          fail_count;
    int          stall_left = 0;
    logic        tx_idle    = 1'b1;
    logic        rx_idle    = 1'b1;
    logic [31:0] cur_dur    = 32'd65536;
    logic [14:0] cur_max    = 15'd1;

    always #6 clk = ~clk;

    particle_emitter_scheduler #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_func(func),
        .i_delta_time(delta_time),
        .i_emitter_x(emitter_x),
        .i_emitter_y(emitter_y),
        .i_emitter_z(emitter_z),
        .i_camera_x(camera_x),
        .i_camera_y(camera_y),
        .i_camera_z(camera_z),
        .i_owner_alive(owner_alive),
        .i_live_total(live_total),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_burst_spawned(burst_spawned),
        .o_rate_spawned(rate_spawned),
        .o_playing(playing)
    );

    particle_emitter_scheduler_checker #(
        .MAX_PARTICLES(MAX_PARTICLES)
    ) u_checker (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid),
        .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .i_in_stall(in_stall),
        .i_func(func),
        .i_delta_time(delta_time),
        .i_emitter_x(emitter_x),
        .i_emitter_y(emitter_y),
        .i_emitter_z(emitter_z),
        .i_camera_x(camera_x),
        .i_camera_y(camera_y),
        .i_camera_z(camera_z),
        .i_owner_alive(owner_alive),
        .i_live_total(live_total),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_burst_spawned(burst_spawned),
        .i_rate_spawned(rate_spawned),
        .i_playing(playing),
        .o_pending(pending),
        .o_fail_count(fail_count)
    );

    // Result side: when rx_idle is set, may hold off after each beat and now and then while waiting
    always @(posedge clk) begin
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end else if ((out_valid && !out_stall) || (rx_idle && $urandom_range(0, 15) == 0)) begin
            n = rx_idle ? $urandom_range(0, 13) : 0;
            stall_left <= n;
            out_stall  <= (n != 0);
        end
    end

    function automatic emit_cmd_t at_camera(input logic [1:0] f, input logic [31:0] dt);
        emit_cmd_t c;
        c.func  = f;
        c.dt    = dt;
        c.ex    = '0;
        c.ey    = '0;
        c.ez    = '0;
        c.cx    = '0;
        c.cy    = '0;
        c.cz    = '0;
        c.owner = '0;
        c.total = '0;
        return c;
    endfunction

    task automatic send_cmd(input emit_cmd_t c);
        int gap;
        gap = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= c.func;
        delta_time  <= c.dt;
        emitter_x   <= c.ex;
        emitter_y   <= c.ey;
        emitter_z   <= c.ez;
        camera_x    <= c.cx;
        camera_y    <= c.cy;
        camera_z    <= c.cz;
        owner_alive <= c.owner;
        live_total  <= c.total;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending and wait for every outstanding result beat
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_emitter(input logic [31:0] sd, input logic [31:0] dur,
                                   input logic lp, input logic [14:0] bc,
                                   input logic [31:0] rate, input logic [14:0] mc,
                                   input logic [31:0] dl);
        write_reg(CFG_START_DELAY, sd);
        write_reg(CFG_DURATION, dur);
        write_reg(CFG_LOOPING, {31'd0, lp});
        write_reg(CFG_BURST_COUNT, {17'd0, bc});
        write_reg(CFG_SPAWN_RATE, rate);
        write_reg(CFG_MAX_COUNT, {17'd0, mc});
        write_reg(CFG_DIST_LIMIT, dl);
        cfg_valid <= 1'b0;
        cur_dur = (dur < MIN_DURATION) ? MIN_DURATION : dur;
        cur_max = (mc == '0) ? 15'd1 : mc;
    endtask

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        emit_cmd_t   c;
        int          r;
        logic [31:0] sd, dur, rate, dl;
        logic        lp;
        logic [14:0] bc, mc;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: 0.5 s delay, 1 s looping period, burst of 5, 10.5 per second
        program_emitter(32'h0000_8000, 32'h0001_0000, 1'b1, 15'd5, 32'h000A_8000,
                        15'd16384, 32'd640000);
        send_cmd(at_camera(FUNC_TICK, 32'h0001_0000));   // stopped: nothing
        send_cmd(at_camera(FUNC_UNUSED, 32'h0001_0000));
        send_cmd(at_camera(FUNC_PLAY, 32'hDEAD_BEEF));   // delta ignored
        send_cmd(at_camera(FUNC_TICK, 32'd0));
        send_cmd(at_camera(FUNC_TICK, 32'h0000_4000));   // still inside the delay
        send_cmd(at_camera(FUNC_TICK, 32'h0000_8000));   // burst and first rate beat
        c = at_camera(FUNC_TICK, 32'h0000_8000);
        c.owner = 15'd16382;                             // owner headroom of two
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0000_8000);
        c.ex = 32'd1000 << 16;                           // out of range, wraps too
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0000_8000);
        c.ex = 32'd800 << 16;                            // right on the limit
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0000_8000);
        c.ex = (32'd800 << 16) + 32'd1;
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0002_0000);
        c.total = 15'd16384;                             // no global headroom
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0000_4000);
        c.total = 15'd16380;
        send_cmd(c);
        send_cmd(at_camera(FUNC_TICK, 32'hFFFF_FFFF));   // saturate elapsed
        c = at_camera(FUNC_TICK, 32'h0000_1000);
        c.ex = 32'h7FFF_FFFF;
        c.ey = 32'h7FFF_FFFF;
        c.ez = 32'h7FFF_FFFF;
        c.cx = 32'h8000_0000;
        c.cy = 32'h8000_0000;
        c.cz = 32'h8000_0000;
        send_cmd(c);
        c = at_camera(FUNC_TICK, 32'h0000_1000);
        c.owner = 15'h7FFF;
        c.total = 15'h7FFF;
        send_cmd(c);
        send_cmd(at_camera(FUNC_STOP, 32'h0000_1000));
        send_cmd(at_camera(FUNC_TICK, 32'h0000_1000));

        // One-shot, shortest period, owner limit of zero (treated as one), huge rate
        drain();
        program_emitter(32'd0, 32'd0, 1'b0, 15'd16384, 32'hFFFF_FFFF, 15'd0, 32'hFFFF_FFFF);
        send_cmd(at_camera(FUNC_PLAY, 32'd0));
        send_cmd(at_camera(FUNC_TICK, 32'd100));         // rate overflow, clamped
        send_cmd(at_camera(FUNC_TICK, 32'hFFFF_FFFF));   // past the period: stop
        send_cmd(at_camera(FUNC_TICK, 32'd100));
        send_cmd(at_camera(FUNC_PLAY, 32'd0));
        send_cmd(at_camera(FUNC_TICK, 32'd600));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                program_emitter(32'd0, 32'd655, 1'b0, 15'd0, 32'd0, 15'd1, 32'd0);
            end else if (ph == 1) begin
                program_emitter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 15'd16384, 32'hFFFF_FFFF,
                                15'd16384, 32'hFFFF_FFFF);
            end else begin
                r  = $urandom_range(0, 99);
                sd = (r < 30) ? 32'd0 : 32'($urandom_range(0, 32'h0002_0000));
                r  = $urandom_range(0, 99);
                dur = (r < 10) ? 32'($urandom_range(0, 654))
                               : 32'($urandom_range(655, 32'h0004_0000));
                lp = ($urandom_range(0, 99) < 70);
                r  = $urandom_range(0, 99);
                bc = (r < 20) ? 15'd0 : (r < 90) ? 15'($urandom_range(1, 64)) : 15'($urandom());
                r  = $urandom_range(0, 99);
                rate = (r < 10) ? 32'd0 : (r < 90) ? 32'($urandom_range(0, 300 << 16))
                                                   : 32'($urandom());
                r  = $urandom_range(0, 99);
                mc = (r < 5) ? 15'd0 : (r < 10) ? 15'($urandom())
                   : (r < 60) ? 15'($urandom_range(1, 2000)) : 15'($urandom_range(1, 16384));
                r  = $urandom_range(0, 99);
                dl = (r < 60) ? 32'd640000 : (r < 90) ? 32'($urandom_range(0, 4000000))
                                                      : 32'($urandom());
                program_emitter(sd, dur, lp, bc, rate, mc, dl);
            end
            tx_idle = (ph % 4 == 0) || (ph % 4 == 2);
            rx_idle <= (ph % 4 == 0) || (ph % 4 == 1);

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 2)
                    drain();
                r = $urandom_range(0, 99);
                c.func = (r < 10) ? FUNC_PLAY : (r < 13) ? FUNC_STOP
                       : (r < 15) ? FUNC_UNUSED : FUNC_TICK;
                r = $urandom_range(0, 99);
                if (r < 4)
                    c.dt = '0;
                else if (r < 12)
                    c.dt = $urandom();
                else if (r < 24)
                    c.dt = $urandom_range(0, (cur_dur > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF
                                                                       : cur_dur << 1);
                else
                    c.dt = $urandom_range(1, (cur_dur >> 2) + 1);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    c.ex = $urandom();
                    c.ey = $urandom();
                    c.ez = $urandom();
                    c.cx = $urandom();
                    c.cy = $urandom();
                    c.cz = $urandom();
                end else begin
                    // camera within 2000 units, emitter within 500 units of it per axis
                    c.cx = 32'($urandom_range(0, 262144000)) - 32'd131072000;
                    c.cy = 32'($urandom_range(0, 262144000)) - 32'd131072000;
                    c.cz = 32'($urandom_range(0, 262144000)) - 32'd131072000;
                    if (r < 15) begin
                        c.ex = c.cx;
                        c.ey = c.cy;
                        c.ez = c.cz;
                    end else begin
                        c.ex = c.cx + 32'($urandom_range(0, 65536000)) - 32'd32768000;
                        c.ey = c.cy + 32'($urandom_range(0, 65536000)) - 32'd32768000;
                        c.ez = c.cz + 32'($urandom_range(0, 65536000)) - 32'd32768000;
                    end
                end
                c.owner = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, cur_max + 4))
                                                       : 15'($urandom());
                c.total = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(0, 16400))
                                                       : 15'($urandom());
                send_cmd(c);
            end
        end

        drain();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/pes_pkg.sv
hw/rtl/pes_dp.sv
hw/rtl/pes_ctrl.sv
hw/rtl/particle_emitter_scheduler.sv
bench/particle_emitter_scheduler_checker.sv
bench/particle_emitter_scheduler_tb.sv
